[hw/rtl/ssd_pkg.sv]
package ssd_pkg;

  // Default size of the pattern store, in bytes.
  localparam int STORE_DEPTH_DEF = 128;

  // Number of display digits; the select table below assumes four.
  localparam int DIGITS  = 4;
  localparam int DIGIT_W = 2;

  // Transaction kinds on the input channel.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_PUSH  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_DIGIT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_REPEAT = 2'd1;
  localparam logic [1:0] CFG_TOTAL  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [2:0] MODE_RESET   = 3'd4;
  localparam logic [7:0] REPEAT_RESET = 8'd5;
  localparam logic [7:0] TOTAL_RESET  = 8'd22;

  // Active-low select pattern for each digit.
  function automatic logic [7:0] sel_pattern(input logic [DIGIT_W-1:0] d);
    logic [7:0] p;
    case (d)
      2'd0:    p = 8'hEE;
      2'd1:    p = 8'hDD;
      2'd2:    p = 8'hBB;
      2'd3:    p = 8'h77;
      default: p = 8'hEE;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/scrolling_segment_display_core.sv]
// Channel | Direction | Ports
// ------- | --------- | ------------------------------------------------------------
// in      | input     | in_valid, in_stall, in_kind, in_pattern_byte, in_digit_index
// out     | output    | out_valid, out_stall, out_digit_select, out_segments,
//         |           | out_fill_count, out_store_empty
// cfg     | input     | cfg_we, cfg_index, cfg_data
//
// Push, clear and direct digit writes are done in the idle state. A tick goes to the
// output state; one that switches frame is paced by the single store read port: after
// prepare, each of the four bytes needs an index step, a memory read and a capture in turn.
// Reset is synchronous and active low; the store contents are not cleared.
// A result held in the output register does not block further push, clear or
// digit transactions; a tick waits until the output register is free.
module scrolling_segment_display_core
  import ssd_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_kind,
  input  logic [7:0]   in_pattern_byte,
  input  logic [1:0]   in_digit_index,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_digit_select,
  output logic [7:0]   out_segments,
  output logic [7:0]   out_fill_count,
  output logic         out_store_empty,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int IW = ((CW > 9) ? CW : 9) + 1;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(STORE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_ADDR   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_DATA   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [7:0]         repeat_r, repeat_nxt;
  logic [7:0]         fc_r, fc_nxt;
  logic [7:0]         fo_r, fo_nxt;
  logic [CW-1:0]      loop_len_r, loop_len_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic [7:0]         rep_cfg_r, rep_cfg_nxt;
  logic [7:0]         ftot_r, ftot_nxt;
  logic [7:0]         digit_r [DIGITS];
  logic [7:0]         digit_nxt [DIGITS];
  logic [DIGIT_W-1:0] j_r, j_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               hit_r, hit_nxt;
  logic [7:0]         pend_sel_r, pend_sel_nxt;
  logic [7:0]         pend_seg_r, pend_seg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_sel_r, out_seg_r, out_fill_r;
  logic               out_empty_r;
  logic [7:0]         rd_data_r;
  logic [7:0]         mem [STORE_DEPTH];

  logic               in_acc;
  logic               out_take;
  logic               out_load;
  logic               push_we;
  logic [AW:0]        push_sum;
  logic [AW-1:0]      push_addr;
  logic [AW:0]        rd_sum;
  logic [AW-1:0]      rd_addr;
  logic [1:0]         phase_inc;
  logic [7:0]         rep_inc;
  logic [7:0]         fc_eff;
  logic [IW-1:0]      idx_base;
  logic [IW-1:0]      idx_sum;
  logic [IW-1:0]      loop_len_w;
  logic [CW-1:0]      pop_n;
  logic [AW:0]        pop_sum;

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign in_stall = (state_r != S_IDLE);

  assign out_valid        = out_valid_r;
  assign out_digit_select = out_sel_r;
  assign out_segments     = out_seg_r;
  assign out_fill_count   = out_fill_r;
  assign out_store_empty  = out_empty_r;

  // Ring addressing for a push and for a store read; both sums stay below twice the depth.
  assign push_we   = in_acc && (in_kind == KIND_PUSH) && (count_r < DEPTH_C);
  assign push_sum  = {1'b0, head_r} + (AW + 1)'(count_r);
  assign push_addr = (push_sum >= DEPTH_A) ? AW'(push_sum - DEPTH_A) : push_sum[AW-1:0];
  assign rd_sum    = {1'b0, head_r} + {1'b0, idx_r[AW-1:0]};
  assign rd_addr   = (rd_sum >= DEPTH_A) ? AW'(rd_sum - DEPTH_A) : rd_sum[AW-1:0];

  assign phase_inc  = phase_r + 2'd1;
  assign rep_inc    = repeat_r + 8'd1;
  assign fc_eff     = (fc_r == ftot_r) ? 8'd0 : fc_r;
  assign loop_len_w = IW'(loop_len_r);

  // Logical index of the byte for digit j; loop by one wraps at the latched length.
  always_comb begin
    if (mode_r[1]) begin
      idx_base = '0;
    end else if (mode_r[0]) begin
      idx_base = IW'(fo_r);
    end else begin
      idx_base = IW'(fc_r);
    end
    idx_sum = idx_base + IW'(j_r);
    if (!mode_r[1] && !mode_r[0] && (loop_len_r != '0) && (idx_sum >= loop_len_w)) begin
      idx_sum = idx_sum - loop_len_w;
    end
  end

  // Pop count saturates at the fill level.
  always_comb begin
    pop_n = mode_r[0] ? CW'(4) : CW'(1);
    if (pop_n > count_r) begin
      pop_n = count_r;
    end
    pop_sum = {1'b0, head_r} + (AW + 1)'(pop_n);
  end

  // Next-state logic for the sequencer and the display state.
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    repeat_nxt   = repeat_r;
    fc_nxt       = fc_r;
    fo_nxt       = fo_r;
    loop_len_nxt = loop_len_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    mode_nxt     = mode_r;
    rep_cfg_nxt  = rep_cfg_r;
    ftot_nxt     = ftot_r;
    j_nxt        = j_r;
    idx_nxt      = idx_r;
    hit_nxt      = hit_r;
    pend_sel_nxt = pend_sel_r;
    pend_seg_nxt = pend_seg_r;
    for (int d = 0; d < DIGITS; d++) begin
      digit_nxt[d] = digit_r[d];
    end

    // Configuration writes; a loop mode restarts the frame sequence.
    if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: begin
          mode_nxt = cfg_data[2:0];
          if (!cfg_data[2]) begin
            repeat_nxt = '0;
          end
          if (cfg_data[2:1] == 2'b00) begin
            fc_nxt       = '0;
            fo_nxt       = '0;
            loop_len_nxt = cfg_data[0] ? (count_r >> 2) : count_r;
          end
        end
        CFG_REPEAT: rep_cfg_nxt = cfg_data;
        CFG_TOTAL:  ftot_nxt    = cfg_data;
        default:    ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_PUSH: begin
              if (count_r < DEPTH_C) begin
                count_nxt = count_r + CW'(1);
              end
            end
            KIND_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
            end
            KIND_DIGIT: begin
              digit_nxt[in_digit_index] = in_pattern_byte;
            end
            KIND_TICK: begin
              phase_nxt    = phase_inc;
              pend_sel_nxt = sel_pattern(phase_inc);
              pend_seg_nxt = digit_r[phase_inc];
              state_nxt    = S_OUT;
              if (phase_inc == 2'd0) begin
                if (!mode_r[2] && (rep_inc == rep_cfg_r)) begin
                  repeat_nxt = '0;
                  j_nxt      = '0;
                  state_nxt  = S_PREP;
                end else begin
                  repeat_nxt = rep_inc;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        // Loop modes wrap after the configured frame total.
        if (!mode_r[1]) begin
          fc_nxt = fc_eff;
          if (fc_r == ftot_r) begin
            fo_nxt = '0;
          end
          if (!mode_r[0]) begin
            fo_nxt = fc_eff;
          end
        end
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        idx_nxt   = idx_sum;
        state_nxt = S_READ;
      end
      S_READ: begin
        hit_nxt   = (idx_r < IW'(count_r));
        state_nxt = S_DATA;
      end
      S_DATA: begin
        digit_nxt[j_r] = hit_r ? rd_data_r : 8'h00;
        j_nxt          = j_r + DIGIT_W'(1);
        state_nxt      = (j_r == DIGIT_W'(DIGITS - 1)) ? S_FINISH : S_ADDR;
      end
      S_FINISH: begin
        fc_nxt = fc_r + 8'd1;
        if (mode_r[1]) begin
          head_nxt  = (pop_sum >= DEPTH_A) ? AW'(pop_sum - DEPTH_A) : pop_sum[AW-1:0];
          count_nxt = count_r - pop_n;
        end else if (mode_r[0]) begin
          fo_nxt = fo_r + 8'd4;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The output register fills from the pending result and empties on acceptance.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      repeat_r    <= '0;
      fc_r        <= '0;
      fo_r        <= '0;
      loop_len_r  <= '0;
      head_r      <= '0;
      count_r     <= '0;
      mode_r      <= MODE_RESET;
      rep_cfg_r   <= REPEAT_RESET;
      ftot_r      <= TOTAL_RESET;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      for (int d = 0; d < DIGITS; d++) begin
        digit_r[d] <= 8'hFF;
      end
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      repeat_r    <= repeat_nxt;
      fc_r        <= fc_nxt;
      fo_r        <= fo_nxt;
      loop_len_r  <= loop_len_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      mode_r      <= mode_nxt;
      rep_cfg_r   <= rep_cfg_nxt;
      ftot_r      <= ftot_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      for (int d = 0; d < DIGITS; d++) begin
        digit_r[d] <= digit_nxt[d];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    pend_sel_r <= pend_sel_nxt;
    pend_seg_r <= pend_seg_nxt;
    if (out_load) begin
      out_sel_r   <= pend_sel_r;
      out_seg_r   <= pend_seg_r;
      out_fill_r  <= 8'(count_r);
      out_empty_r <= (count_r == '0);
    end
  end

  // Pattern store: one write port for pushes, one registered read port for frames.
  always_ff @(posedge clk) begin
    if (push_we) begin
      mem[push_addr] <= in_pattern_byte;
    end
    if (state_r == S_READ) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

[test/tb_scrolling_segment_display_core.sv]
`timescale 1ns / 1ps

module tb_scrolling_segment_display_core;
  import ssd_pkg::*;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 24;

  // Display modes as held in the mode register.
  localparam logic [2:0] MODE_LOOP1    = 3'd0;
  localparam logic [2:0] MODE_LOOP4    = 3'd1;
  localparam logic [2:0] MODE_CLEAR1   = 3'd2;
  localparam logic [2:0] MODE_CLEAR4   = 3'd3;
  localparam logic [2:0] MODE_LIVE     = 3'd4;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  // Register index past the end of the register list.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pattern;
    logic [1:0] digit;
  } panel_item_t;

  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segments;
    logic [7:0] fill_count;
    logic       store_empty;
  } scan_result_t;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_stall;
  logic [1:0] in_kind         = '0;
  logic [7:0] in_pattern_byte = '0;
  logic [1:0] in_digit_index  = '0;
  logic       out_valid;
  logic       out_stall       = 1'b0;
  logic [7:0] out_digit_select;
  logic [7:0] out_segments;
  logic [7:0] out_fill_count;
  logic       out_store_empty;
  logic       cfg_we          = 1'b0;
  logic [1:0] cfg_index       = '0;
  logic [7:0] cfg_data        = '0;

  scrolling_segment_display_core u_top (.*);

  always #2 clk = ~clk;

  // Transactions waiting to be sent, and scan results waiting to arrive.
  panel_item_t  pending_items[$];
  scan_result_t expected_scans[$];

  logic in_accepted = 1'b0;
  logic gaps_on     = 1'b1;
  int   send_wait   = 0;
  int   stall_wait  = 0;
  int   cycle_cnt   = 0;
  int   fail_cnt    = 0;
  int   items_taken = 0;
  int   results_checked = 0;
  int   frame_switches  = 0;
  int   pushes_dropped  = 0;

  // Predicted state of the display and its registers.
  logic [2:0] disp_mode   = MODE_RESET;
  logic [7:0] repeat_cfg  = REPEAT_RESET;
  logic [7:0] total_cfg   = TOTAL_RESET;
  logic [7:0] pat_mem [STORE_DEPTH_DEF];
  int         fill_head   = 0;
  int         fill_cnt    = 0;
  logic [7:0] digit_reg [DIGITS];
  logic [1:0] scan_phase  = '0;
  logic [7:0] refresh_cnt = '0;
  logic [7:0] frame_cnt   = '0;
  logic [7:0] frame_off   = '0;
  int         loop_len    = 0;

  function automatic int ring_slot(input int i);
    return (fill_head + i) % STORE_DEPTH_DEF;
  endfunction

  // Logical store read; anything at or past the fill level reads as zero.
  function automatic logic [7:0] held_byte(input int i);
    if (i >= fill_cnt) return 8'h00;
    return pat_mem[ring_slot(i)];
  endfunction

  // Mostly short gaps, now and then a long one; none in quiet stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Frame switch after a completed refresh, according to the display mode.
  task automatic switch_frame();
    int idx;
    int pop_n;
    if (disp_mode <= MODE_CLEAR4 && refresh_cnt == repeat_cfg) begin
      refresh_cnt = '0;
      frame_switches++;
      if (disp_mode == MODE_CLEAR1 || disp_mode == MODE_CLEAR4) begin
        for (int j = 0; j < DIGITS; j++) digit_reg[j] = held_byte(j);
        pop_n = (disp_mode == MODE_CLEAR4) ? 4 : 1;
        if (pop_n > fill_cnt) pop_n = fill_cnt;
        fill_head = (fill_head + pop_n) % STORE_DEPTH_DEF;
        fill_cnt -= pop_n;
      end else begin
        if (frame_cnt == total_cfg) begin
          frame_cnt = '0;
          frame_off = '0;
        end
        if (disp_mode == MODE_LOOP4) begin
          for (int j = 0; j < DIGITS; j++) digit_reg[j] = held_byte(int'(frame_off) + j);
          frame_off = frame_off + 8'd4;
        end else begin
          frame_off = frame_cnt;
          for (int j = 0; j < DIGITS; j++) begin
            idx = int'(frame_cnt) + j;
            if (loop_len != 0 && idx >= loop_len) idx -= loop_len;
            digit_reg[j] = held_byte(idx);
          end
        end
      end
      frame_cnt = frame_cnt + 8'd1;
    end
  endtask

  // Works out what one accepted transaction does to the display.
  task automatic step_display(input panel_item_t it, output logic emitted,
                              output scan_result_t res);
    emitted = 1'b0;
    res = '0;
    case (it.kind)
      KIND_PUSH: begin
        if (fill_cnt < STORE_DEPTH_DEF) begin
          pat_mem[ring_slot(fill_cnt)] = it.pattern;
          fill_cnt++;
        end else begin
          pushes_dropped++;
        end
      end
      KIND_CLEAR: begin
        fill_head = 0;
        fill_cnt = 0;
      end
      KIND_DIGIT: digit_reg[it.digit] = it.pattern;
      default: begin
        scan_phase = scan_phase + 2'd1;
        res.digit_select = ~(8'h11 << scan_phase);
        res.segments = digit_reg[scan_phase];
        if (scan_phase == 2'd0) begin
          refresh_cnt = refresh_cnt + 8'd1;
          switch_frame();
        end
        res.fill_count = 8'(fill_cnt);
        res.store_empty = (fill_cnt == 0);
        emitted = 1'b1;
      end
    endcase
  endtask

  task automatic apply_register(input logic [1:0] idx, input logic [7:0] val);
    case (idx)
      CFG_MODE: begin
        disp_mode = val[2:0];
        if (disp_mode <= MODE_CLEAR4) refresh_cnt = '0;
        if (disp_mode <= MODE_LOOP4) begin
          frame_cnt = '0;
          frame_off = '0;
          loop_len = (disp_mode == MODE_LOOP4) ? fill_cnt / 4 : fill_cnt;
        end
      end
      CFG_REPEAT: repeat_cfg = val;
      CFG_TOTAL:  total_cfg = val;
      default: ;
    endcase
  endtask

  // Sender: a new transaction goes out once the previous one has been taken.
  always @(negedge clk) begin
    panel_item_t next_item;
    if (rst_n && (!in_valid || in_accepted)) begin
      if (send_wait == 0 && pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_kind <= next_item.kind;
        in_pattern_byte <= next_item.pattern;
        in_digit_index <= next_item.digit;
        in_valid <= 1'b1;
        send_wait = pick_gap();
      end else begin
        if (send_wait != 0) send_wait--;
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (stall_wait == 0) stall_wait = pick_gap();
    else stall_wait--;
    out_stall <= (stall_wait != 0);
  end

  // Monitor: runs the predictor on accepted transactions and checks results.
  always @(posedge clk) begin
    scan_result_t want;
    scan_result_t got;
    logic         emitted;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_cnt);
      $display("FAILURE");
      $finish;
    end else begin
      in_accepted = rst_n && in_valid && !in_stall;
      if (rst_n && cfg_we) apply_register(cfg_index, cfg_data);
      if (in_accepted) begin
        items_taken++;
        step_display('{in_kind, in_pattern_byte, in_digit_index}, emitted, want);
        if (emitted) expected_scans.push_back(want);
      end
      if (rst_n && out_valid && !out_stall) begin
        got = '{out_digit_select, out_segments, out_fill_count, out_store_empty};
        if (expected_scans.size() == 0) begin
          $error("scan result with nothing expected: select %h segments %h",
                 got.digit_select, got.segments);
          fail_cnt++;
        end else begin
          want = expected_scans.pop_front();
          results_checked++;
          if (got.digit_select !== want.digit_select) begin
            $error("digit_select: expected %h, got %h", want.digit_select, got.digit_select);
            fail_cnt++;
          end
          if (got.segments !== want.segments) begin
            $error("segments: expected %h, got %h", want.segments, got.segments);
            fail_cnt++;
          end
          if (got.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
            fail_cnt++;
          end
          if (got.store_empty !== want.store_empty) begin
            $error("store_empty: expected %b, got %b", want.store_empty, got.store_empty);
            fail_cnt++;
          end
        end
      end
    end
  end

  task automatic queue_item(input logic [1:0] kind, input logic [7:0] pattern,
                            input logic [1:0] digit);
    pending_items.push_back('{kind, pattern, digit});
  endtask

  // Random transactions; weights in percent, digit writes take the remainder.
  task automatic queue_random(input int n, input int w_tick, input int w_push,
                              input int w_clear);
    int r;
    logic [1:0] kind;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_tick) kind = KIND_TICK;
      else if (r < w_tick + w_push) kind = KIND_PUSH;
      else if (r < w_tick + w_push + w_clear) kind = KIND_CLEAR;
      else kind = KIND_DIGIT;
      queue_item(kind, 8'($urandom), 2'($urandom));
    end
  endtask

  // Waits until the block has nothing left to do, then lets it settle.
  task automatic wait_idle();
    @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_scans.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One phase: settings written while idle, an optional store fill, then traffic.
  task automatic run_phase(input logic [2:0] mode_v, input logic [7:0] rep_v,
                           input logic [7:0] total_v, input int prefill, input int n,
                           input int w_tick, input int w_push, input int w_clear,
                           input logic gaps_v);
    wait_idle();
    gaps_on = gaps_v;
    write_reg(CFG_REPEAT, rep_v);
    write_reg(CFG_TOTAL, total_v);
    if (prefill > 0) begin
      queue_random(prefill, 0, 100, 0);
      wait_idle();
    end
    write_reg(CFG_MODE, {5'($urandom), mode_v});
    queue_random(n, w_tick, w_push, w_clear);
  endtask

  initial begin
    int need;
    int ticks_left;
    for (int j = 0; j < DIGITS; j++) digit_reg[j] = 8'hFF;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset digits, direct writes at the extremes, push and clear in live mode.
    repeat (4) queue_item(KIND_TICK, 8'h00, 2'd0);
    queue_item(KIND_DIGIT, 8'h00, 2'd0);
    queue_item(KIND_DIGIT, 8'hFF, 2'd1);
    queue_item(KIND_DIGIT, 8'h5A, 2'd2);
    queue_item(KIND_DIGIT, 8'hA5, 2'd3);
    repeat (4) queue_item(KIND_TICK, 8'hFF, 2'd3);
    queue_item(KIND_PUSH, 8'hFF, 2'd0);
    queue_item(KIND_PUSH, 8'h00, 2'd2);
    queue_item(KIND_CLEAR, 8'h00, 2'd1);
    queue_item(KIND_TICK, 8'h00, 2'd0);
    queue_item(KIND_PUSH, 8'h81, 2'd0);
    wait_idle();

    // Clear by four with a single byte held, so the pop saturates at empty.
    write_reg(CFG_REPEAT, 8'd1);
    write_reg(CFG_MODE, {5'b00000, MODE_CLEAR4});
    repeat (5) queue_item(KIND_TICK, 8'h00, 2'd0);
    wait_idle();

    // A write past the register list, then an unused mode that acts as live.
    write_reg(CFG_SPARE, 8'hFF);
    write_reg(CFG_TOTAL, 8'd1);
    write_reg(CFG_MODE, {5'b11111, MODE_SPARE_HI});
    repeat (4) queue_item(KIND_TICK, 8'h00, 2'd0);

    // Loop by one over a short store, so indexes wrap and run past the fill.
    run_phase(MODE_LOOP1, 8'd1, 8'($urandom_range(3, 8)), $urandom_range(4, 12),
              40, 80, 12, 1, 1'b1);
    run_phase(MODE_LOOP4, 8'd2, 8'($urandom_range(1, 4)), $urandom_range(8, 32),
              40, 80, 12, 1, 1'b1);
    run_phase(MODE_CLEAR1, 8'd1, 8'd255, $urandom_range(8, 24), 40, 75, 20, 1, 1'b0);
    run_phase(MODE_CLEAR4, 8'($urandom_range(1, 3)), 8'($urandom), $urandom_range(8, 24),
              40, 75, 20, 1, 1'b1);
    // Overfilled store: pushes past the depth are dropped.
    run_phase(MODE_LOOP1, 8'd1, 8'd255, 132, 30, 85, 10, 0, 1'b1);

    // Loop by one entered with an empty store, so the loop length is zero.
    wait_idle();
    queue_item(KIND_CLEAR, 8'($urandom), 2'($urandom));
    run_phase(MODE_LOOP1, 8'd1, 8'($urandom_range(3, 10)), 0, 30, 70, 25, 0, 1'b1);

    run_phase(MODE_SPARE_LO + 3'($urandom_range(0, 2)), 8'($urandom_range(1, 255)),
              8'($urandom), 0, 20, 25, 25, 10, 1'b1);
    run_phase(MODE_LOOP4, 8'd1, 8'd0, $urandom_range(16, 32), 30, 85, 10, 1, 1'b0);

    // Refresh counter run: repeat 255 up to a count of 254, then repeat zero,
    // so the next frame switch only comes when the counter wraps.
    wait_idle();
    gaps_on = 1'b1;
    write_reg(CFG_REPEAT, 8'd255);
    write_reg(CFG_MODE, {5'($urandom), MODE_CLEAR1});
    for (int i = 0; i < 1000; i++) begin
      if ($urandom_range(0, 19) == 0) queue_random(1, 0, 70, 2);
      queue_item(KIND_TICK, 8'($urandom), 2'($urandom));
    end
    wait_idle();
    need = 254 - int'(refresh_cnt);
    ticks_left = (need - 1) * 4 + ((scan_phase == 2'd0) ? 4 : 4 - int'(scan_phase));
    repeat (ticks_left) queue_item(KIND_TICK, 8'($urandom), 2'($urandom));
    wait_idle();
    write_reg(CFG_REPEAT, 8'd0);
    queue_random(60, 85, 10, 1);

    run_phase(MODE_LIVE, 8'($urandom_range(1, 4)), 8'($urandom), 0, 20, 25, 25, 10, 1'b1);

    wait_idle();
    $display("Checked %0d scan results over %0d accepted transactions.",
             results_checked, items_taken);
    $display("Frame switches: %0d; pushes dropped on a full store: %0d.",
             frame_switches, pushes_dropped);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ssd_pkg.sv
hw/rtl/scrolling_segment_display_core.sv
test/tb_scrolling_segment_display_core.sv
